@@ hw/rtl/sapd_pkg.sv @@
package sapd_pkg;

  localparam int NUM_AXES_MAX = 6;
  localparam int AXES         = 6;
  localparam int NUM_STEPS    = 6;

  localparam int FORCE_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int COEFF_W    = 17;
  localparam int INV_TS_W   = 24;
  localparam int MASK_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [COEFF_W-1:0]  COEFF_ONE     = 17'h10000;
  localparam logic [INV_TS_W-1:0] INV_TS_RESET  = 24'd256000;

  localparam logic [CFG_IDX_W-1:0] REG_KP_LO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_HI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_LO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD_HI   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TS  = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } sapd_state_t;

  typedef struct packed {
    logic                 load;
    logic [NUM_STEPS-1:0] step;
  } sapd_ctl_t;

  typedef logic [NUM_AXES_MAX-1:0][FORCE_W-1:0] sapd_vec_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/sapd_lane.sv @@
module sapd_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sapd_pkg::sapd_ctl_t                 ctl,
  input  logic signed [sapd_pkg::FORCE_W-1:0] target,
  input  logic signed [sapd_pkg::FORCE_W-1:0] measured,
  input  logic                                enable,
  input  logic signed [sapd_pkg::GAIN_W-1:0]  kp,
  input  logic signed [sapd_pkg::GAIN_W-1:0]  kd,
  input  logic [sapd_pkg::COEFF_W-1:0]        coeff,
  input  logic [sapd_pkg::INV_TS_W-1:0]       inv_ts,
  output logic signed [sapd_pkg::FORCE_W-1:0] cmd
);

  logic signed [32:0] e_r, e_nxt;
  logic signed [31:0] filt_r;
  logic signed [51:0] fprod_r, fprod_nxt;
  logic signed [48:0] pprod_r, pprod_nxt;
  logic signed [32:0] diff_r, diff_nxt;
  logic signed [36:0] pterm_r, pterm_nxt;
  logic signed [57:0] rprod_r, rprod_nxt;
  logic signed [49:0] rate_r, rate_nxt;
  logic signed [65:0] dprod_r, dprod_nxt;
  logic signed [31:0] cmd_r, cmd_nxt;

  logic signed [33:0] ediff;
  logic signed [17:0] coeff_s;
  logic signed [24:0] inv_s;
  logic signed [51:0] fround;
  logic signed [35:0] fstep;
  logic signed [36:0] fsum;
  logic signed [31:0] fnew;
  logic signed [48:0] pround;
  logic signed [57:0] rround;
  logic signed [65:0] dround;
  logic signed [53:0] dterm;
  logic signed [54:0] total;

  always_comb begin
    e_nxt = enable ? ($signed({target[31], target}) - $signed({measured[31], measured}))
                   : 33'sd0;

    // filter product and proportional product
    ediff     = $signed({e_r[32], e_r}) - $signed({{2{filt_r[31]}}, filt_r});
    coeff_s   = $signed({1'b0, coeff});
    fprod_nxt = ediff * coeff_s;
    pprod_nxt = kp * e_r;

    // filter update, filter difference and proportional term rounding
    fround    = fprod_r + 52'sd32768;
    fstep     = fround[51:16];
    fsum      = $signed({fstep[35], fstep}) + $signed({{5{filt_r[31]}}, filt_r});
    fnew      = sapd_pkg::sat32($signed({{27{fsum[36]}}, fsum}));
    diff_nxt  = $signed({fnew[31], fnew}) - $signed({filt_r[31], filt_r});
    pround    = pprod_r + 49'sd2048;
    pterm_nxt = pround[48:12];

    // derivative rate
    inv_s     = $signed({1'b0, inv_ts});
    rprod_nxt = diff_r * inv_s;
    rround    = rprod_r + 58'sd128;
    rate_nxt  = rround[57:8];

    // derivative term and sum
    dprod_nxt = kd * rate_r;
    dround    = dprod_r + 66'sd2048;
    dterm     = dround[65:12];
    total     = $signed({dterm[53], dterm}) + $signed({{18{pterm_r[36]}}, pterm_r});
    cmd_nxt   = sapd_pkg::sat32($signed({{9{total[54]}}, total}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (ctl.step[1]) begin
      filt_r <= fnew;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      e_r <= e_nxt;
    end
    if (ctl.step[0]) begin
      fprod_r <= fprod_nxt;
      pprod_r <= pprod_nxt;
    end
    if (ctl.step[1]) begin
      diff_r  <= diff_nxt;
      pterm_r <= pterm_nxt;
    end
    if (ctl.step[2]) begin
      rprod_r <= rprod_nxt;
    end
    if (ctl.step[3]) begin
      rate_r <= rate_nxt;
    end
    if (ctl.step[4]) begin
      dprod_r <= dprod_nxt;
    end
    if (ctl.step[5]) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd = cmd_r;

endmodule

@@ hw/rtl/sapd_out.sv @@
module sapd_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sapd_pkg::sapd_vec_t cmd,
  input  logic                out_ready,
  output logic                free,
  output logic                out_valid,
  output sapd_pkg::sapd_vec_t data
);

  logic                valid_r, valid_nxt;
  sapd_pkg::sapd_vec_t data_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= cmd;
    end
  end

  assign out_valid = valid_r;
  assign data      = data_r;

endmodule

@@ hw/rtl/six_axis_force_pd_control_core.sv @@
// Six-axis force PD controller with filtered derivative.
// Input channel (in_valid/in_ready): one request carries six target and six
// measured forces, signed Q15.16. Result channel (out_valid/out_ready): one
// request of six saturated velocity commands per input request.
// Config port: cfg_wr_en/cfg_index/cfg_wdata, single-cycle write, no read-back;
// write only while the block is idle. Unknown indexes are ignored.
// Six lanes, one per axis, run side by side through the error load and a
// six-step sequence (filter/P products, filter update, rate product, rate round,
// D product, sum/saturate); the output register gathers all six lanes.
// After the last step the sequencer waits until the output register is free,
// then loads it and raises out_valid. A new request is taken only once the
// previous one has left the lanes; in_ready is high again while the previous
// result still waits in the output register.
// A stalled receiver holds the output register; a finished request then
// waits in the lanes, and in_ready stays low until the output register frees.
// Reset (rst_n, sync, active low) clears the filtered errors, all config
// registers to their defaults, and the handshake state.
module six_axis_force_pd_control_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_target_force_0,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_target_force_1,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_target_force_2,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_target_force_3,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_target_force_4,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_target_force_5,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_measured_force_0,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_measured_force_1,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_measured_force_2,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_measured_force_3,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_measured_force_4,
  input  logic signed [sapd_pkg::FORCE_W-1:0]    in_measured_force_5,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [sapd_pkg::FORCE_W-1:0]    out_velocity_cmd_0,
  output logic signed [sapd_pkg::FORCE_W-1:0]    out_velocity_cmd_1,
  output logic signed [sapd_pkg::FORCE_W-1:0]    out_velocity_cmd_2,
  output logic signed [sapd_pkg::FORCE_W-1:0]    out_velocity_cmd_3,
  output logic signed [sapd_pkg::FORCE_W-1:0]    out_velocity_cmd_4,
  output logic signed [sapd_pkg::FORCE_W-1:0]    out_velocity_cmd_5,
  input  logic                                   cfg_wr_en,
  input  logic [sapd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sapd_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  logic [sapd_pkg::CFG_DATA_W-1:0] kp_lo_r, kp_hi_r, kd_lo_r, kd_hi_r;
  logic [sapd_pkg::MASK_W-1:0]     mask_r;
  logic [sapd_pkg::COEFF_W-1:0]    coeff_r;
  logic [sapd_pkg::INV_TS_W-1:0]   inv_ts_r;
  logic [sapd_pkg::COEFF_W-1:0]    coeff_eff;

  sapd_pkg::sapd_state_t state_r, state_nxt;
  logic [sapd_pkg::NUM_STEPS-1:0] step_r, step_nxt;
  sapd_pkg::sapd_ctl_t ctl;

  logic                accept;
  logic                free;
  logic                load_out;
  sapd_pkg::sapd_vec_t tgt, meas, cmd, data;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_lo_r  <= '0;
      kp_hi_r  <= '0;
      kd_lo_r  <= '0;
      kd_hi_r  <= '0;
      mask_r   <= '0;
      coeff_r  <= sapd_pkg::COEFF_ONE;
      inv_ts_r <= sapd_pkg::INV_TS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sapd_pkg::REG_KP_LO:  kp_lo_r  <= cfg_wdata;
        sapd_pkg::REG_KP_HI:  kp_hi_r  <= cfg_wdata;
        sapd_pkg::REG_KD_LO:  kd_lo_r  <= cfg_wdata;
        sapd_pkg::REG_KD_HI:  kd_hi_r  <= cfg_wdata;
        sapd_pkg::REG_MASK:   mask_r   <= cfg_wdata[sapd_pkg::MASK_W-1:0];
        sapd_pkg::REG_COEFF:  coeff_r  <= cfg_wdata[sapd_pkg::COEFF_W-1:0];
        sapd_pkg::REG_INV_TS: inv_ts_r <= cfg_wdata[sapd_pkg::INV_TS_W-1:0];
        default: ;
      endcase
    end
  end

  assign coeff_eff = (coeff_r > sapd_pkg::COEFF_ONE) ? sapd_pkg::COEFF_ONE : coeff_r;

  // sequencer
  assign in_ready = (state_r == sapd_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == sapd_pkg::S_WAIT) && free;
  assign step_nxt = {step_r[sapd_pkg::NUM_STEPS-2:0], accept};
  assign ctl.load = accept;
  assign ctl.step = step_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sapd_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = sapd_pkg::S_RUN;
        end
      end
      sapd_pkg::S_RUN: begin
        if (step_r[sapd_pkg::NUM_STEPS-1]) begin
          state_nxt = sapd_pkg::S_WAIT;
        end
      end
      sapd_pkg::S_WAIT: begin
        if (free) begin
          state_nxt = sapd_pkg::S_IDLE;
        end
      end
      default: state_nxt = sapd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sapd_pkg::S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // lanes
  assign tgt  = {in_target_force_5, in_target_force_4, in_target_force_3,
                 in_target_force_2, in_target_force_1, in_target_force_0};
  assign meas = {in_measured_force_5, in_measured_force_4, in_measured_force_3,
                 in_measured_force_2, in_measured_force_1, in_measured_force_0};

  for (genvar i = 0; i < sapd_pkg::NUM_AXES_MAX; i++) begin : g_lane
    if (i < sapd_pkg::AXES) begin : g_on
      logic [sapd_pkg::CFG_DATA_W-1:0] kp_reg, kd_reg;
      assign kp_reg = (i < 3) ? kp_lo_r : kp_hi_r;
      assign kd_reg = (i < 3) ? kd_lo_r : kd_hi_r;

      sapd_lane u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .target   ($signed(tgt[i])),
        .measured ($signed(meas[i])),
        .enable   (mask_r[i]),
        .kp       ($signed(kp_reg[sapd_pkg::GAIN_W*(i%3) +: sapd_pkg::GAIN_W])),
        .kd       ($signed(kd_reg[sapd_pkg::GAIN_W*(i%3) +: sapd_pkg::GAIN_W])),
        .coeff    (coeff_eff),
        .inv_ts   (inv_ts_r),
        .cmd      (cmd[i])
      );
    end else begin : g_off
      assign cmd[i] = '0;
    end
  end

  sapd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load_out),
    .cmd       (cmd),
    .out_ready (out_ready),
    .free      (free),
    .out_valid (out_valid),
    .data      (data)
  );

  assign out_velocity_cmd_0 = data[0];
  assign out_velocity_cmd_1 = data[1];
  assign out_velocity_cmd_2 = data[2];
  assign out_velocity_cmd_3 = data[3];
  assign out_velocity_cmd_4 = data[4];
  assign out_velocity_cmd_5 = data[5];

endmodule

@@ verif/tb_six_axis_force_pd_control_core.sv @@
module tb_six_axis_force_pd_control_core;
  import sapd_pkg::*;

  typedef logic signed [95:0] wide_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1530;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sapd_vec_t             tgt_drv = '0;
  sapd_vec_t             meas_drv = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sapd_vec_t             cmd_obs;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // controller copy: registers and filtered error per axis
  logic [47:0]         kp_lo_r, kp_hi_r, kd_lo_r, kd_hi_r;
  logic [MASK_W-1:0]   mask_r;
  logic [COEFF_W-1:0]  coeff_r;
  logic [INV_TS_W-1:0] inv_ts_r;
  logic signed [31:0]  filt_err [NUM_AXES_MAX];

  sapd_vec_t pending_cmds [$];
  sapd_vec_t walk_tgt;

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cmds_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_pos = 0;

  six_axis_force_pd_control_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_target_force_0   (tgt_drv[0]),
    .in_target_force_1   (tgt_drv[1]),
    .in_target_force_2   (tgt_drv[2]),
    .in_target_force_3   (tgt_drv[3]),
    .in_target_force_4   (tgt_drv[4]),
    .in_target_force_5   (tgt_drv[5]),
    .in_measured_force_0 (meas_drv[0]),
    .in_measured_force_1 (meas_drv[1]),
    .in_measured_force_2 (meas_drv[2]),
    .in_measured_force_3 (meas_drv[3]),
    .in_measured_force_4 (meas_drv[4]),
    .in_measured_force_5 (meas_drv[5]),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_velocity_cmd_0  (cmd_obs[0]),
    .out_velocity_cmd_1  (cmd_obs[1]),
    .out_velocity_cmd_2  (cmd_obs[2]),
    .out_velocity_cmd_3  (cmd_obs[3]),
    .out_velocity_cmd_4  (cmd_obs[4]),
    .out_velocity_cmd_5  (cmd_obs[5]),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic wide_t round_sh(wide_t x, int s);
    wide_t half;
    half = wide_t'(1);
    half = half <<< (s - 1);
    return (x + half) >>> s;
  endfunction

  function automatic wide_t clamp32(wide_t x);
    wide_t hi, lo;
    hi = wide_t'(2147483647);
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic logic signed [15:0] gain_slot(logic [47:0] lo, logic [47:0] hi, int axis);
    logic [47:0] r;
    r = (axis < 3) ? lo : hi;
    return r[16*(axis%3) +: 16];
  endfunction

  // PD law with filtered derivative; advances the filtered error
  function automatic sapd_vec_t compute_velocity_cmds(sapd_vec_t tgt, sapd_vec_t meas);
    sapd_vec_t          cmds;
    wide_t              e, m, p, f, c, rk, kp, kd, pterm, rate, dterm, sum;
    logic signed [31:0] ts, ms;
    logic signed [15:0] g;
    c  = wide_t'((coeff_r > COEFF_ONE) ? COEFF_ONE : coeff_r);
    rk = wide_t'(inv_ts_r);
    for (int i = 0; i < NUM_AXES_MAX; i++) begin
      ts = tgt[i];
      ms = meas[i];
      e = wide_t'(ts);
      m = wide_t'(ms);
      e = e - m;
      if (!mask_r[i]) e = '0;
      p = wide_t'(filt_err[i]);
      f = clamp32(p + round_sh(c * (e - p), 16));
      g = gain_slot(kp_lo_r, kp_hi_r, i);
      kp = wide_t'(g);
      g = gain_slot(kd_lo_r, kd_hi_r, i);
      kd = wide_t'(g);
      pterm = round_sh(kp * e, 12);
      rate  = round_sh((f - p) * rk, 8);
      dterm = round_sh(kd * rate, 12);
      filt_err[i] = f[31:0];
      sum = clamp32(pterm + dterm);
      cmds[i] = sum[31:0];
    end
    return cmds;
  endfunction

  always @(posedge clk) begin
    sapd_vec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        $display("%0t: command set with no request outstanding", $time);
      end else begin
        want = pending_cmds.pop_front();
        cmds_checked++;
        for (int i = 0; i < NUM_AXES_MAX; i++) begin
          if (want[i] !== cmd_obs[i]) begin
            mismatches++;
            $display("%0t: axis %0d velocity cmd expected %0d actual %0d",
                     $time, i, $signed(want[i]), $signed(cmd_obs[i]));
          end
        end
      end
    end
  end

  // receiver stall pattern, re-rolled each time pat_pos wraps to zero
  always @(negedge clk) begin
    out_ready = stalls_on ? ready_pat[pat_pos] : 1'b1;
    pat_pos = (pat_pos + 1) % 16;
    if (pat_pos == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pat = 16'hFFFF;
        1: ready_pat = 16'($urandom);
        2: ready_pat = 16'($urandom & $urandom);
        default: ready_pat = 16'($urandom | $urandom);
      endcase
    end
  end

  task automatic send_forces(input sapd_vec_t tgt, input sapd_vec_t meas);
    if (gaps_on && burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    tgt_drv  = tgt;
    meas_drv = meas;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_cmds.push_back(compute_velocity_cmds(tgt, meas));
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      REG_KP_LO:  kp_lo_r  = data;
      REG_KP_HI:  kp_hi_r  = data;
      REG_KD_LO:  kd_lo_r  = data;
      REG_KD_HI:  kd_hi_r  = data;
      REG_MASK:   mask_r   = data[MASK_W-1:0];
      REG_COEFF:  coeff_r  = data[COEFF_W-1:0];
      REG_INV_TS: inv_ts_r = data[INV_TS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [47:0] junk48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [31:0] rand_force();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hFFFFFFFF;
      4, 5: return $urandom_range(0, 2**21) - 2**20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] rand_gain_reg();
    logic [47:0] r;
    case ($urandom_range(0, 5))
      0: r = {3{16'h7FFF}};
      1: r = {3{16'h8000}};
      2: r = '0;
      3: begin
        for (int s = 0; s < 3; s++)
          r[16*s +: 16] = 16'($urandom_range(0, 16'h2000)) - 16'h1000;
      end
      default: r = junk48();
    endcase
    return r;
  endfunction

  task automatic write_mask(input logic [MASK_W-1:0] m);
    logic [47:0] d;
    d = junk48();
    d[MASK_W-1:0] = m;
    cfg_write(REG_MASK, d);
  endtask

  task automatic write_coeff(input logic [COEFF_W-1:0] c);
    logic [47:0] d;
    d = junk48();
    d[COEFF_W-1:0] = c;
    cfg_write(REG_COEFF, d);
  endtask

  task automatic write_inv_ts(input logic [INV_TS_W-1:0] r);
    logic [47:0] d;
    d = junk48();
    d[INV_TS_W-1:0] = r;
    cfg_write(REG_INV_TS, d);
  endtask

  task automatic test_reset_defaults();
    send_forces({6{32'h7FFFFFFF}}, {6{32'h80000000}});
    send_forces({6{32'h12345678}}, '0);
    send_forces('0, {6{32'h7FFFFFFF}});
  endtask

  task automatic test_saturation_extremes();
    sapd_vec_t a, b;
    drain();
    cfg_write(REG_KP_LO, {3{16'h7FFF}});
    cfg_write(REG_KP_HI, {3{16'h8000}});
    cfg_write(REG_KD_LO, {3{16'h8000}});
    cfg_write(REG_KD_HI, {3{16'h7FFF}});
    write_mask(6'h3F);
    write_coeff(COEFF_ONE);
    write_inv_ts(24'hFFFFFF);
    send_forces({6{32'h7FFFFFFF}}, {6{32'h80000000}});
    send_forces({6{32'h80000000}}, {6{32'h7FFFFFFF}});
    send_forces('0, '0);
    send_forces({6{32'h80000000}}, {6{32'h80000000}});
    for (int i = 0; i < NUM_AXES_MAX; i++) begin
      a[i] = i[0] ? 32'h7FFFFFFF : 32'h00000001;
      b[i] = i[0] ? 32'hFFFFFFFF : 32'h80000000;
    end
    send_forces(a, b);
    send_forces(b, a);
  endtask

  task automatic test_filter_mask_rate();
    drain();
    cfg_write(REG_KP_LO, {3{16'h1000}});
    cfg_write(REG_KP_HI, {3{16'h1000}});
    cfg_write(REG_KD_LO, {3{16'h1000}});
    cfg_write(REG_KD_HI, {3{16'hF000}});
    write_inv_ts(INV_TS_RESET);
    // frozen filter: no derivative action
    write_coeff('0);
    send_forces({6{32'h00010000}}, '0);
    send_forces({6{32'hFFFF0000}}, {6{32'h00008000}});
    // coefficient above one clamps to one
    drain();
    write_coeff(17'h1FFFF);
    send_forces({6{32'h00030000}}, {6{32'h00000001}});
    send_forces('0, {6{32'h00050000}});
    drain();
    write_coeff(17'd1);
    send_forces({6{32'h7FFF0000}}, {6{32'h80010000}});
    // zero sample rate
    drain();
    write_coeff(17'd32768);
    write_inv_ts('0);
    send_forces({6{32'h00020000}}, '0);
    send_forces({6{32'h00000003}}, {6{32'h00000004}});
    // masked axes keep decaying
    drain();
    write_inv_ts(INV_TS_RESET);
    write_mask(6'b101010);
    repeat (3) send_forces({6{32'h00040000}}, {6{32'hFFFC0000}});
  endtask

  task automatic test_ignored_index();
    drain();
    cfg_write(REG_UNUSED, junk48());
    send_forces({6{32'h00011111}}, {6{32'h00002222}});
    send_forces({6{32'hFFF00000}}, {6{32'h00100000}});
  endtask

  task automatic test_random_phases();
    sapd_vec_t   tgt, meas;
    int          sent, style, n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      cfg_write(REG_KP_LO, rand_gain_reg());
      cfg_write(REG_KP_HI, rand_gain_reg());
      cfg_write(REG_KD_LO, rand_gain_reg());
      cfg_write(REG_KD_HI, rand_gain_reg());
      case ($urandom_range(0, 3))
        0: write_mask('0);
        1: write_mask(6'h3F);
        default: write_mask(6'($urandom));
      endcase
      case ($urandom_range(0, 5))
        0: write_coeff('0);
        1: write_coeff(COEFF_ONE);
        2: write_coeff(17'($urandom_range(65537, 131071)));
        3: write_coeff(17'd1);
        default: write_coeff(17'($urandom_range(0, 65536)));
      endcase
      case ($urandom_range(0, 6))
        0: write_inv_ts('0);
        1: write_inv_ts(24'hFFFFFF);
        2: write_inv_ts(INV_TS_RESET);
        3: write_inv_ts(24'd1);
        default: write_inv_ts(24'($urandom_range(1, 20000)));
      endcase
      style     = $urandom_range(0, 3);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(60, 200);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      for (int i = 0; i < NUM_AXES_MAX; i++)
        walk_tgt[i] = $urandom_range(0, 2**24) - 2**23;
      for (int k = 0; k < n; k++) begin
        for (int i = 0; i < NUM_AXES_MAX; i++) begin
          case (style)
            0: begin
              tgt[i]  = $urandom;
              meas[i] = $urandom;
            end
            1: begin
              tgt[i]  = rand_force();
              meas[i] = rand_force();
            end
            default: begin
              // smooth tracking: small errors, occasional step
              if ($urandom_range(0, 31) == 0) walk_tgt[i] = rand_force();
              else walk_tgt[i] = walk_tgt[i] + ($urandom_range(0, 2**18) - 2**17);
              tgt[i]  = walk_tgt[i];
              meas[i] = walk_tgt[i] + ($urandom_range(0, 2**12) - 2**11);
            end
          endcase
        end
        send_forces(tgt, meas);
        sent++;
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    kp_lo_r  = '0;
    kp_hi_r  = '0;
    kd_lo_r  = '0;
    kd_hi_r  = '0;
    mask_r   = '0;
    coeff_r  = COEFF_ONE;
    inv_ts_r = INV_TS_RESET;
    for (int i = 0; i < NUM_AXES_MAX; i++) filt_err[i] = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_saturation_extremes();
    test_filter_mask_rate();
    test_ignored_index();
    test_random_phases();
    drain();

    $display("Sent %0d force requests, checked %0d command sets, %0d register writes",
             items_sent, cmds_checked, cfg_writes);
    $display("Covered gain and force extremes, filter clamp, masked axes, zero rate");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
